/* rtl/qpe_pkg.sv */
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, constants and helpers of the quoted-printable encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

  localparam logic [7:0] LINE_BUDGET_RESET = 8'd73;

  localparam logic       CFG_DOT_STUFFING = 1'b0;
  localparam logic       CFG_LINE_BUDGET  = 1'b1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_COUNT_W = $clog2(CMD_DEPTH + 1);

  localparam int SLOT_COUNT = 10;
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

  localparam logic [SLOT_IDX_W-1:0] SLOT_PRE_EQ   = SLOT_IDX_W'(0);
  localparam logic [SLOT_IDX_W-1:0] SLOT_PRE_CR   = SLOT_IDX_W'(1);
  localparam logic [SLOT_IDX_W-1:0] SLOT_PRE_LF   = SLOT_IDX_W'(2);
  localparam logic [SLOT_IDX_W-1:0] SLOT_DOT      = SLOT_IDX_W'(3);
  localparam logic [SLOT_IDX_W-1:0] SLOT_BODY0    = SLOT_IDX_W'(4);
  localparam logic [SLOT_IDX_W-1:0] SLOT_BODY1    = SLOT_IDX_W'(5);
  localparam logic [SLOT_IDX_W-1:0] SLOT_BODY2    = SLOT_IDX_W'(6);
  localparam logic [SLOT_IDX_W-1:0] SLOT_POST_EQ  = SLOT_IDX_W'(7);
  localparam logic [SLOT_IDX_W-1:0] SLOT_POST_CR  = SLOT_IDX_W'(8);
  localparam logic [SLOT_IDX_W-1:0] SLOT_POST_LF  = SLOT_IDX_W'(9);

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_HEX  = 2'd1,
    KIND_SP20 = 2'd2,
    KIND_NL   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       pre_break;
    logic       dot;
    kind_t      kind;
    logic [7:0] data;
    logic       post_break;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return CH_UPPER_A + {4'd0, d} - 8'd10;
  endfunction

endpackage

/* rtl/quoted_printable_encoder.sv */
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// Quoted-printable encoder with CRLF line ends and optional dot stuffing.
//
// Input side is a queue: present in_byte/end_of_text with push; a
// transaction completes on a clock edge with push high and full low.
// Output side is a queue: while empty is low, out_byte/run_last hold the
// oldest encoded character; pop high with empty low takes it. run_last
// marks the final character caused by one input byte.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 dot stuffing,
// 1 line budget) and cfg_data; cfg_ready is always high. Write only while
// the block is idle.
// A byte's first character passes the command queue and the sequencer's
// command register into the output register. Throughput: one output character
// per cycle while commands wait and the receiver pops; qpe_back turns a
// byte into 1 to 9 characters (1 for plain text, 3 for an encoded byte).
// A four-entry command queue lets input keep flowing while output stalls.
// Reset: synchronous; clears the queues, sets line budget 73, dot
// stuffing off, and the line-start flag. A stalled receiver holds the
// current character; input stalls once the command queue fills.
// ----------------------------------------------------------------------------
module quoted_printable_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import qpe_pkg::*;

  cmd_t front_cmd;
  cmd_t fifo_cmd;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_not_empty;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;

  qpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (front_cmd)
  );

  qpe_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_cmd    (front_cmd),
    .full      (cmd_full),
    .rd_en     (cmd_pop),
    .rd_cmd    (fifo_cmd),
    .not_empty (cmd_not_empty)
  );

  qpe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .fifo_cmd       (fifo_cmd),
    .fifo_not_empty (cmd_not_empty),
    .fifo_pop       (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .run_last       (run_last)
  );

endmodule

/* rtl/qpe_front.sv */
// ----------------------------------------------------------------------------
// qpe_front
// Accepts message bytes, tracks the line budget and classifies each byte
// into one encoding command.
// ----------------------------------------------------------------------------
module qpe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_byte,
  input  logic          end_of_text,
  input  logic          cfg_valid,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          cmd_full,
  output logic          cmd_push,
  output qpe_pkg::cmd_t cmd
);
  import qpe_pkg::*;

  logic              dot_stuffing;
  logic [7:0]        line_budget;
  logic signed [8:0] budget_left;
  logic signed [8:0] budget_left_next;
  logic              at_line_start;
  logic              at_line_start_next;

  logic              is_nl;
  logic              is_enc;
  logic              spent;
  logic              line_open;
  logic              pre_break;
  logic              dot;
  logic signed [8:0] base;
  logic signed [8:0] after_dot;
  logic signed [8:0] cost;
  kind_t             kind;

  assign cmd_push = push && !cmd_full;

  always_comb begin
    is_nl     = (in_byte == CH_LF);
    is_enc    = (in_byte < CH_SPACE) || (in_byte == CH_EQUAL) || (in_byte > CH_TILDE);
    spent     = budget_left[8] || (budget_left == 9'sd0);
    pre_break = !is_nl && !at_line_start && spent;
    line_open = at_line_start || pre_break;
    base      = line_open ? $signed({1'b0, line_budget}) : budget_left;
    dot       = line_open && dot_stuffing && (in_byte == CH_DOT);
    after_dot = base - $signed({8'd0, dot});
    priority if (is_nl) begin
      kind = KIND_NL;
      cost = 9'sd0;
    end else if (is_enc) begin
      kind = KIND_HEX;
      cost = 9'sd3;
    end else if ((in_byte == CH_SPACE) && (after_dot == 9'sd1)) begin
      kind = KIND_SP20;
      cost = 9'sd1;
    end else begin
      kind = KIND_LIT;
      cost = 9'sd1;
    end
    budget_left_next   = after_dot - cost;
    at_line_start_next = is_nl || end_of_text;

    cmd.pre_break  = pre_break;
    cmd.dot        = dot;
    cmd.kind       = kind;
    cmd.data       = in_byte;
    cmd.post_break = end_of_text && !is_nl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_stuffing  <= 1'b0;
      line_budget   <= LINE_BUDGET_RESET;
      budget_left   <= $signed({1'b0, LINE_BUDGET_RESET});
      at_line_start <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DOT_STUFFING: dot_stuffing <= cfg_data[0];
          CFG_LINE_BUDGET:  line_budget  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd_push) begin
        budget_left   <= budget_left_next;
        at_line_start <= at_line_start_next;
      end
    end
  end

endmodule

/* rtl/qpe_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// qpe_cmd_fifo
// Short command queue between the classifier and the character sequencer.
// ----------------------------------------------------------------------------
module qpe_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  qpe_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output qpe_pkg::cmd_t rd_cmd,
  output logic          not_empty
);
  import qpe_pkg::*;

  cmd_t                   slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_ptr;
  logic [CMD_PTR_W-1:0]   rd_ptr;
  logic [CMD_COUNT_W-1:0] count;

  assign full      = (count == CMD_COUNT_W'(CMD_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CMD_COUNT_W'(1);
        2'b01:   count <= count - CMD_COUNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/qpe_back.sv */
// ----------------------------------------------------------------------------
// qpe_back
// Expands each command into encoded characters into an output register,
// one per cycle unless the receiver stalls the output.
// ----------------------------------------------------------------------------
module qpe_back (
  input  logic          clk,
  input  logic          rst,
  input  qpe_pkg::cmd_t fifo_cmd,
  input  logic          fifo_not_empty,
  output logic          fifo_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          run_last
);
  import qpe_pkg::*;

  cmd_t                  cur;
  logic [SLOT_COUNT-1:0] mask;
  logic [SLOT_COUNT-1:0] mask_next;
  logic [SLOT_COUNT-1:0] mask_clr;
  logic [SLOT_COUNT-1:0] load_mask;
  logic [SLOT_IDX_W-1:0] idx;
  logic                  out_valid;
  logic                  active;
  logic                  advance;
  logic                  emit;
  logic                  load;
  logic [7:0]            ch;

  function automatic logic [SLOT_COUNT-1:0] slots_of(input cmd_t c);
    logic [SLOT_COUNT-1:0] m;
    m = '0;
    m[SLOT_PRE_EQ]  = c.pre_break;
    m[SLOT_PRE_CR]  = c.pre_break;
    m[SLOT_PRE_LF]  = c.pre_break;
    m[SLOT_DOT]     = c.dot;
    m[SLOT_BODY0]   = 1'b1;
    m[SLOT_BODY1]   = (c.kind != KIND_LIT);
    m[SLOT_BODY2]   = (c.kind == KIND_HEX) || (c.kind == KIND_SP20);
    m[SLOT_POST_EQ] = c.post_break;
    m[SLOT_POST_CR] = c.post_break;
    m[SLOT_POST_LF] = c.post_break;
    return m;
  endfunction

  always_comb begin
    idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    unique case (idx)
      SLOT_PRE_EQ, SLOT_POST_EQ: ch = CH_EQUAL;
      SLOT_PRE_CR, SLOT_POST_CR: ch = CH_CR;
      SLOT_PRE_LF, SLOT_POST_LF: ch = CH_LF;
      SLOT_DOT:                  ch = CH_DOT;
      SLOT_BODY0: begin
        unique case (cur.kind)
          KIND_NL:  ch = CH_CR;
          KIND_LIT: ch = cur.data;
          default:  ch = CH_EQUAL;
        endcase
      end
      SLOT_BODY1: begin
        unique case (cur.kind)
          KIND_NL:   ch = CH_LF;
          KIND_SP20: ch = CH_TWO;
          default:   ch = hex_digit(4'((cur.data & HI_NIBBLE_MASK) >> 4));
        endcase
      end
      SLOT_BODY2: begin
        unique case (cur.kind)
          KIND_SP20: ch = CH_ZERO;
          default:   ch = hex_digit(4'(cur.data & LO_NIBBLE_MASK));
        endcase
      end
      default: ch = CH_EQUAL;
    endcase
  end

  always_comb begin
    active    = (mask != '0);
    advance   = !out_valid || pop;
    emit      = active && advance;
    mask_clr  = mask & ~(SLOT_COUNT'(1) << idx);
    load      = fifo_not_empty && (!active || (emit && (mask_clr == '0)));
    load_mask = slots_of(fifo_cmd);
    if (load) begin
      mask_next = load_mask;
    end else if (emit) begin
      mask_next = mask_clr;
    end else begin
      mask_next = mask;
    end
  end

  assign fifo_pop = load;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= fifo_cmd;
    end
    if (emit) begin
      out_byte <= ch;
      run_last <= (mask_clr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= mask_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* test/tb_quoted_printable_encoder.sv */
// ----------------------------------------------------------------------------
// tb_quoted_printable_encoder
// Self-checking bench for the quoted-printable encoder. A behavioral encoder
// predicts the character stream of every accepted byte; a monitor compares
// each popped character field by field. Directed tests cover byte classes,
// dot stuffing, budget reload and soft breaks; random message traffic runs
// under several register settings with random gaps on both queue sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_quoted_printable_encoder;
  import qpe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAUSE = 4;
  localparam int END_PAUSE   = 16;
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } qp_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_DOT_STUFFING;
  logic [7:0] cfg_data = 8'h00;

  qp_char_t   expected_chars[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         tx_max_gap = 7;
  int         rx_max_gap = 7;
  int         rx_hold_cycles = 0;

  logic       stuff_dots = 1'b0;
  logic [7:0] line_width = LINE_BUDGET_RESET;
  int         room_left = LINE_BUDGET_RESET;
  logic       line_fresh = 1'b1;

  quoted_printable_encoder dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .end_of_text(end_of_text),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .run_last(run_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_quoted_printable_encoder: errors");
      $finish;
    end
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + 8'(d);
    end
    return CH_UPPER_A + 8'(d) - 8'd10;
  endfunction

  function automatic void predict_encoding(input logic [7:0] b, input logic eot);
    logic [7:0] chars[$];
    qp_char_t   entry;
    if (b != CH_LF && !line_fresh && room_left <= 0) begin
      chars.push_back(CH_EQUAL);
      chars.push_back(CH_CR);
      chars.push_back(CH_LF);
      line_fresh = 1'b1;
    end
    if (line_fresh) begin
      room_left = int'(line_width);
      if (stuff_dots && b == CH_DOT) begin
        chars.push_back(CH_DOT);
        room_left--;
      end
      line_fresh = 1'b0;
    end
    if (b == CH_LF) begin
      chars.push_back(CH_CR);
      chars.push_back(CH_LF);
      line_fresh = 1'b1;
    end else if (b < CH_SPACE || b == CH_EQUAL || b > CH_TILDE) begin
      chars.push_back(CH_EQUAL);
      chars.push_back(nibble_char(b[7:4]));
      chars.push_back(nibble_char(b[3:0]));
      room_left -= 3;
    end else if (b == CH_SPACE && room_left == 1) begin
      chars.push_back(CH_EQUAL);
      chars.push_back(CH_TWO);
      chars.push_back(CH_ZERO);
      room_left--;
    end else begin
      chars.push_back(b);
      room_left--;
    end
    if (eot && !line_fresh) begin
      chars.push_back(CH_EQUAL);
      chars.push_back(CH_CR);
      chars.push_back(CH_LF);
      line_fresh = 1'b1;
    end
    foreach (chars[i]) begin
      entry.ch = chars[i];
      entry.last = (i == chars.size() - 1);
      expected_chars.push_back(entry);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    qp_char_t want;
    if (!rst && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h", out_byte));
      end else begin
        want = expected_chars.pop_front();
        if (out_byte !== want.ch) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.ch));
        end
        if (run_last !== want.last) begin
          report_mismatch($sformatf("run_last %0b, want %0b on %02h",
                                    run_last, want.last, want.ch));
        end
      end
    end
  end

  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        pop = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_max_gap);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_byte = b;
    end_of_text = eot;
    do @(posedge clk); while (full);
    predict_encoding(b, eot);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DOT_STUFFING) begin
      stuff_dots = value[0];
    end else begin
      line_width = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] random_msg_byte(input int lf_pct, input int raw_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < lf_pct) begin
      return CH_LF;
    end
    if (pick < lf_pct + raw_pct) begin
      return 8'($urandom_range(1, 255));
    end
    if (pick < lf_pct + raw_pct + 6) begin
      return CH_DOT;
    end
    if (pick < lf_pct + raw_pct + 14) begin
      return CH_SPACE;
    end
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic test_byte_classes();
    logic [7:0] bytes[11] = '{8'h00, 8'h01, 8'h09, CH_CR, 8'h1F, CH_SPACE,
                              CH_EQUAL, CH_TILDE, 8'h7F, 8'h80, 8'hFF};
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == 10);
    end
    wait_drained();
  endtask

  task automatic test_dot_stuffing();
    write_reg(CFG_DOT_STUFFING, 8'd1);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_DOT, 1'b1);
    wait_drained();
    write_reg(CFG_DOT_STUFFING, 8'd0);
  endtask

  task automatic test_budget_reload();
    send_byte("p", 1'b0);
    send_byte("q", 1'b0);
    wait_drained();
    write_reg(CFG_LINE_BUDGET, 8'd0);
    send_byte("r", 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    wait_drained();
  endtask

  task automatic test_soft_break();
    write_reg(CFG_LINE_BUDGET, 8'd4);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte("d", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b1);
    wait_drained();
  endtask

  task automatic test_receiver_hold_off();
    tx_max_gap = 0;
    rx_max_gap = 3;
    rx_hold_cycles = 250;
    repeat (24) begin
      send_byte(random_msg_byte(8, 20), $urandom_range(0, 7) == 0);
    end
    wait_drained();
    tx_max_gap = 7;
    rx_max_gap = 7;
  endtask

  task automatic test_random_messages();
    int sent;
    int msg_len;
    int lf_pct;
    int raw_pct;
    int target;
    logic eot;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_DOT_STUFFING, 8'd1);
          write_reg(CFG_LINE_BUDGET, 8'd4);
        end
        1: begin
          write_reg(CFG_DOT_STUFFING, 8'd0);
          write_reg(CFG_LINE_BUDGET, 8'd255);
        end
        2: begin
          write_reg(CFG_DOT_STUFFING, 8'($urandom_range(0, 1)));
          write_reg(CFG_LINE_BUDGET, LINE_BUDGET_RESET);
        end
        default: begin
          write_reg(CFG_DOT_STUFFING, 8'($urandom_range(0, 1)));
          write_reg(CFG_LINE_BUDGET, 8'($urandom_range(4, 255)));
        end
      endcase
      tx_max_gap = (phase % 2 == 1) ? 0 : 7;
      rx_max_gap = (phase % 3 == 1) ? 0 : 7;
      lf_pct = (phase == 1) ? 0 : 8;
      raw_pct = (phase == 1) ? 100 : 16;
      target = (phase == 1) ? 150 : 36;
      sent = 0;
      while (sent < target) begin
        msg_len = (phase == 1) ? target : $urandom_range(1, 24);
        for (int i = 0; i < msg_len; i++) begin
          eot = (i == msg_len - 1) || ($urandom_range(0, 29) == 0);
          send_byte(random_msg_byte(lf_pct, raw_pct), eot);
          sent++;
        end
      end
      wait_drained();
    end
    tx_max_gap = 7;
    rx_max_gap = 7;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_byte_classes();
    test_dot_stuffing();
    test_budget_reload();
    test_soft_break();
    test_receiver_hold_off();
    test_random_messages();
    wait_drained();
    repeat (END_PAUSE) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_quoted_printable_encoder: clean");
    end else begin
      $display("tb_quoted_printable_encoder: errors");
    end
    $finish;
  end

endmodule
